/* design/lss_pkg.sv */
// Package for the lift safety supervisor: field widths, mode and fault codes,
// configuration register indexes and reset values, and the input beat layout.
// No dependencies.
`default_nettype none

package lss_pkg;

    // Field widths.
    localparam int PosW   = 16;
    localparam int PctW   = 7;
    localparam int CurW   = 16;
    localparam int LoadW  = 16;
    localparam int CodeW  = 3;
    localparam int CntW   = 16;
    localparam int CfgW   = 16;
    localparam int CfgIdxW = 3;

    // Stream widths: 69 input bits padded to 72, 8 output bits.
    localparam int InDataW  = 72;
    localparam int OutDataW = 8;

    // Mode codes.
    localparam logic [CodeW-1:0] MODE_IDLE      = 3'd0;
    localparam logic [CodeW-1:0] MODE_DOOR_OPEN = 3'd1;
    localparam logic [CodeW-1:0] MODE_OVERLOAD  = 3'd2;
    localparam logic [CodeW-1:0] MODE_FAULT     = 3'd3;
    localparam logic [CodeW-1:0] MODE_ESTOP     = 3'd4;

    // Fault codes.
    localparam logic [CodeW-1:0] FAULT_NONE        = 3'd0;
    localparam logic [CodeW-1:0] FAULT_ESTOP       = 3'd1;
    localparam logic [CodeW-1:0] FAULT_OVERTRAVEL  = 3'd2;
    localparam logic [CodeW-1:0] FAULT_DOOR_JAM    = 3'd3;
    localparam logic [CodeW-1:0] FAULT_OVERCURRENT = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_OVERTRAVEL_LIMIT  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DOOR_OPEN_LIMIT   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OVERCURRENT_LIMIT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OVERCURRENT_TICKS = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OVERLOAD_SET      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OVERLOAD_CLEAR    = 3'd5;

    // Configuration reset values.
    localparam logic [PosW-1:0]  RST_OVERTRAVEL_LIMIT  = 16'd1005;
    localparam logic [PctW-1:0]  RST_DOOR_OPEN_LIMIT   = 7'd5;
    localparam logic [CurW-1:0]  RST_OVERCURRENT_LIMIT = 16'd15000;
    localparam logic [CntW-1:0]  RST_OVERCURRENT_TICKS = 16'd50;
    localparam logic [LoadW-1:0] RST_OVERLOAD_SET      = 16'd900;
    localparam logic [LoadW-1:0] RST_OVERLOAD_CLEAR    = 16'd850;

    // One decoded input beat.
    typedef struct packed {
        logic             estop;
        logic [PosW-1:0]  position_cm;
        logic [PctW-1:0]  door_pct;
        logic [PctW-1:0]  hoist_duty;
        logic [CurW-1:0]  current_ma;
        logic [LoadW-1:0] load_kg;
        logic [CodeW-1:0] mode_in;
        logic [CodeW-1:0] fault_in;
    } tick_t;

endpackage

`default_nettype wire

/* design/lift_safety_supervisor.sv */
// Lift safety supervisor top level: input register, one pass of safety
// checks and an output register. Depends on lss_pkg.
`default_nettype none

// Usage:
// Each beat on the s_ channel is one evaluation tick carrying the sensor
// readings, the current mode and the current fault code. Each tick gives
// exactly one beat on the m_ channel with the new mode, the fault code, the
// overload flag and the safety-active flag.
// A beat is taken at an edge where tvalid and tready are both high. The
// result beat passes through the input register and then the output
// register before it shows on the m_ channel. One tick is taken per cycle
// sustained while m_tready stays high; the check logic and the overcurrent
// counter update sit between the two registers.
// When the receiver stalls, the output register holds its beat and the
// input register still accepts one more tick; s_tready drops only when both
// are full and m_tready is low. Reset clears both valid bits, the
// overcurrent counter and the overload latch, and loads the configuration
// registers with their default limits. Configuration is written through
// cfg_we/cfg_index/cfg_data while no tick is in flight; indexes beyond the
// last register are ignored.
module lift_safety_supervisor
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input ticks. tdata from bit 0 up: estop, position_cm, door_pct,
    // hoist_duty, current_ma, load_kg, mode_in, fault_in, zero padding.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lss_pkg::InDataW-1:0]    s_tdata,
    // Results. tdata from bit 0 up: mode_out, fault_out, overload_flag,
    // safety_active.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lss_pkg::OutDataW-1:0]        m_tdata,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [lss_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [lss_pkg::CfgW-1:0]       cfg_data
);
    import lss_pkg::*;

    // Configuration registers.
    logic [PosW-1:0]  ot_limit_reg;
    logic [PctW-1:0]  door_limit_reg;
    logic [CurW-1:0]  oc_limit_reg;
    logic [CntW-1:0]  oc_ticks_reg;
    logic [LoadW-1:0] ovl_set_reg;
    logic [LoadW-1:0] ovl_clear_reg;

    // Pipeline registers and state.
    logic             s1_valid_reg;
    tick_t            s1_reg;
    tick_t            tick_in;
    logic             out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;
    logic [CntW-1:0]  oc_count_reg;
    logic [CntW-1:0]  oc_count_next;
    logic             ovl_reg;
    logic             ovl_next;

    // Handshake.
    logic             out_ready;
    logic             s1_adv;
    logic             s_take;

    // Check results.
    logic             over_travel;
    logic             door_jam;
    logic             over_current;
    logic [CntW-1:0]  oc_count_inc;
    logic             oc_trip;
    logic [CodeW-1:0] mode_res;
    logic [CodeW-1:0] fault_res;
    logic             safety_res;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign s_take    = s_tvalid && s_tready;

    // Unpack an input beat.
    always_comb
    begin
        tick_in.estop       = s_tdata[0];
        tick_in.position_cm = s_tdata[16:1];
        tick_in.door_pct    = s_tdata[23:17];
        tick_in.hoist_duty  = s_tdata[30:24];
        tick_in.current_ma  = s_tdata[46:31];
        tick_in.load_kg     = s_tdata[62:47];
        tick_in.mode_in     = s_tdata[65:63];
        tick_in.fault_in    = s_tdata[68:66];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ot_limit_reg   <= RST_OVERTRAVEL_LIMIT;
            door_limit_reg <= RST_DOOR_OPEN_LIMIT;
            oc_limit_reg   <= RST_OVERCURRENT_LIMIT;
            oc_ticks_reg   <= RST_OVERCURRENT_TICKS;
            ovl_set_reg    <= RST_OVERLOAD_SET;
            ovl_clear_reg  <= RST_OVERLOAD_CLEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OVERTRAVEL_LIMIT:  ot_limit_reg   <= cfg_data;
                REG_DOOR_OPEN_LIMIT:   door_limit_reg <= cfg_data[PctW-1:0];
                REG_OVERCURRENT_LIMIT: oc_limit_reg   <= cfg_data;
                REG_OVERCURRENT_TICKS: oc_ticks_reg   <= cfg_data;
                REG_OVERLOAD_SET:      ovl_set_reg    <= cfg_data;
                REG_OVERLOAD_CLEAR:    ovl_clear_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            s1_reg <= tick_in;
        end
    end

    // Raw comparisons against the limits.
    assign over_travel  = s1_reg.position_cm > ot_limit_reg;
    assign door_jam     = (s1_reg.door_pct > door_limit_reg) && (s1_reg.hoist_duty != '0);
    assign over_current = s1_reg.current_ma > oc_limit_reg;
    assign oc_count_inc = (oc_count_reg == '1) ? oc_count_reg : oc_count_reg + 1'b1;
    assign oc_trip      = oc_count_inc >= oc_ticks_reg;

    // Priority checks, then overload hysteresis when no check decided.
    always_comb
    begin
        mode_res      = s1_reg.mode_in;
        fault_res     = s1_reg.fault_in;
        oc_count_next = oc_count_reg;
        ovl_next      = ovl_reg;
        if (s1_reg.estop)
        begin
            mode_res  = MODE_ESTOP;
            fault_res = FAULT_ESTOP;
        end
        else if (over_travel)
        begin
            mode_res  = MODE_FAULT;
            fault_res = FAULT_OVERTRAVEL;
        end
        else if (door_jam)
        begin
            mode_res  = MODE_FAULT;
            fault_res = FAULT_DOOR_JAM;
        end
        else if (over_current && oc_trip)
        begin
            oc_count_next = oc_count_inc;
            mode_res      = MODE_FAULT;
            fault_res     = FAULT_OVERCURRENT;
        end
        else
        begin
            oc_count_next = over_current ? oc_count_inc : '0;
            if (s1_reg.load_kg > ovl_set_reg)
            begin
                ovl_next  = 1'b1;
                fault_res = FAULT_NONE;
                if (s1_reg.mode_in == MODE_IDLE || s1_reg.mode_in == MODE_DOOR_OPEN)
                begin
                    mode_res = MODE_OVERLOAD;
                end
            end
            else if (ovl_reg && (s1_reg.load_kg < ovl_clear_reg))
            begin
                ovl_next  = 1'b0;
                fault_res = FAULT_NONE;
                if (s1_reg.mode_in == MODE_OVERLOAD)
                begin
                    mode_res = MODE_IDLE;
                end
            end
            else if (s1_reg.mode_in == MODE_OVERLOAD && s1_reg.fault_in == FAULT_NONE)
            begin
                mode_res = MODE_IDLE;
            end
        end
    end

    assign safety_res = s1_reg.estop || (fault_res != FAULT_NONE) ||
                        (mode_res == MODE_FAULT) || (mode_res == MODE_ESTOP);

    // State update and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_count_reg  <= '0;
            ovl_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                oc_count_reg <= oc_count_next;
                ovl_reg      <= ovl_next;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= {safety_res, ovl_next, fault_res, mode_res};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result in fault or estop mode always reports safety active.
    a_mode_safety: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == MODE_FAULT || m_tdata[2:0] == MODE_ESTOP))
        |-> m_tdata[7])
        else $error("safety_active low in fault or estop mode");

    // The reported overload flag tracks the latch while the beat is shown.
    a_ovl_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6] == ovl_reg))
        else $error("overload flag differs from latch");

    // The overcurrent counter saturates: from all ones it only clears to zero and never wraps.
    a_oc_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(oc_count_reg) == '1 && oc_count_reg != '1) |-> (oc_count_reg == '0))
        else $error("overcurrent counter wrapped");

    // A tick with normal current and no early exit clears the counter.
    a_oc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_reg.estop && !over_travel && !door_jam && !over_current)
        |=> (oc_count_reg == '0))
        else $error("overcurrent counter not cleared");

    // State only moves when a tick leaves the input register.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> ($stable(oc_count_reg) && $stable(ovl_reg)))
        else $error("state changed without a tick");

endmodule

`default_nettype wire
